// ===== hdl/esc_pkg.sv =====
// Shared types and constants for the environment sensor compensation pipeline.
package esc_pkg;

  typedef enum logic [2:0] {
    CFG_TEMP_ONE   = 3'd0,
    CFG_TEMP_TWO   = 3'd1,
    CFG_TEMP_THREE = 3'd2,
    CFG_HUM_ONE    = 3'd3,
    CFG_HUM_TWO    = 3'd4,
    CFG_HUM_LINEAR = 3'd5,
    CFG_HUM_SQUARE = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic [15:0] t1;
    logic [15:0] t2;
    logic [7:0]  t3;
    logic [11:0] h1;
    logic [11:0] h2;
    logic [23:0] hlin;
    logic [15:0] hsq;
  } cal_t;

  localparam int TEMP_LAT = 8;
  localparam int HUM_LAT  = 20;
  localparam int PIPE_LAT = TEMP_LAT + HUM_LAT;

  localparam logic signed [14:0] TC_MIN = -15'sd4000;
  localparam logic signed [14:0] TC_MAX = 15'sd8500;
  localparam logic signed [31:0] TQ_MAX = 32'sd1426063360;
  localparam logic signed [31:0] TQ_MIN = -32'sd671088640;
  localparam logic [38:0] Y_SAT_POS = 39'd7130316805;
  localparam logic [38:0] Y_SAT_NEG = 39'd3355443205;
  localparam logic [32:0] RECIP5    = 33'd6871947673;
  localparam logic [16:0] HM_MAX    = 17'd100000;

endpackage

// ===== hdl/env_sensor_compensation.sv =====
// Top level of the environment sensor compensation block with calibration registers.
// Throughput is one beat per cycle unless an output beat waits, set by the fixed pipeline.
// The whole pipeline holds while an output beat waits, so in_tready is low only at that time.
// Synchronous active-low reset clears the valid bits and all calibration registers to zero.
module env_sensor_compensation (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // raw_temperature [19:0], raw_humidity [35:20], zero [39:36]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // temperature_centi [14:0], humidity_milli [31:15]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  localparam int LAT = esc_pkg::PIPE_LAT;

  esc_pkg::cal_t      cal_r, cal_nxt;
  logic [LAT-1:0]     vld_r;
  logic               en;
  logic [15:0]        rawh_dly_r [0:esc_pkg::TEMP_LAT-1];
  logic signed [14:0] tc_dly_r [0:esc_pkg::HUM_LAT-1];
  logic signed [14:0] tc;
  logic signed [31:0] tq;
  logic [16:0]        hm;

  assign en         = !vld_r[LAT-1] || out_tready;
  assign in_tready  = en;
  assign out_tvalid = vld_r[LAT-1];
  assign out_tdata  = {hm, tc_dly_r[esc_pkg::HUM_LAT-1]};
  assign cfg_ready  = 1'b1;

  always_comb begin
    cal_nxt = cal_r;
    if (cfg_valid) begin
      case (esc_pkg::cfg_idx_t'(cfg_index))
        esc_pkg::CFG_TEMP_ONE:   cal_nxt.t1   = cfg_data[15:0];
        esc_pkg::CFG_TEMP_TWO:   cal_nxt.t2   = cfg_data[15:0];
        esc_pkg::CFG_TEMP_THREE: cal_nxt.t3   = cfg_data[7:0];
        esc_pkg::CFG_HUM_ONE:    cal_nxt.h1   = cfg_data[11:0];
        esc_pkg::CFG_HUM_TWO:    cal_nxt.h2   = cfg_data[11:0];
        esc_pkg::CFG_HUM_LINEAR: cal_nxt.hlin = cfg_data;
        esc_pkg::CFG_HUM_SQUARE: cal_nxt.hsq  = cfg_data[15:0];
        default: cal_nxt = cal_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_r <= '0;
      vld_r <= '0;
    end else begin
      cal_r <= cal_nxt;
      if (en) begin
        vld_r <= {vld_r[LAT-2:0], in_tvalid};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rawh_dly_r[0] <= in_tdata[35:20];
      for (int i = 1; i < esc_pkg::TEMP_LAT; i++) begin
        rawh_dly_r[i] <= rawh_dly_r[i-1];
      end
      tc_dly_r[0] <= tc;
      for (int i = 1; i < esc_pkg::HUM_LAT; i++) begin
        tc_dly_r[i] <= tc_dly_r[i-1];
      end
    end
  end

  esc_temp u_temp (
    .clk(clk), .en(en), .cal(cal_r), .raw_t(in_tdata[19:0]), .tc(tc), .tq(tq)
  );

  esc_hum u_hum (
    .clk(clk), .en(en), .cal(cal_r), .tq(tq),
    .raw_h(rawh_dly_r[esc_pkg::TEMP_LAT-1]), .hm(hm)
  );

endmodule

// ===== hdl/esc_mulrs.sv =====
// Pipelined sign-magnitude multiplier with round-half-away shift, three stages.
module esc_mulrs #(
  parameter int WA = 32,
  parameter int WB = 32,
  parameter int SH = 16,
  parameter int WR = 48
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [WA-1:0]        a,
  input  logic [WB-1:0]        b,
  input  logic                 neg,
  output logic signed [WR-1:0] res
);

  localparam int LA = WA / 2;
  localparam int LB = WB / 2;
  localparam int HA = WA - LA;
  localparam int HB = WB - LB;
  localparam int WP = WA + WB;
  localparam int WS = WP + 1;
  localparam int WM = WP - SH + 1;

  logic [LA+LB-1:0] p00_r, p00_nxt;
  logic [LA+HB-1:0] p01_r, p01_nxt;
  logic [HA+LB-1:0] p10_r, p10_nxt;
  logic [HA+HB-1:0] p11_r, p11_nxt;
  logic             neg1_r, neg2_r;
  logic [WP-1:0]    lo_r, lo_nxt, hi_r, hi_nxt;
  logic [WS-1:0]    sum;
  logic signed [WM:0] smag, sres;
  logic signed [WR-1:0] res_r, res_nxt;

  assign p00_nxt = a[LA-1:0] * b[LB-1:0];
  assign p01_nxt = a[LA-1:0] * b[WB-1:LB];
  assign p10_nxt = a[WA-1:LA] * b[LB-1:0];
  assign p11_nxt = a[WA-1:LA] * b[WB-1:LB];

  assign lo_nxt = WP'(p00_r) + (WP'(p01_r) << LB);
  assign hi_nxt = (WP'(p10_r) << LA) + (WP'(p11_r) << (LA + LB));

  assign sum     = WS'(lo_r) + WS'(hi_r) + (WS'(1) << (SH - 1));
  assign smag    = $signed({1'b0, sum[WP:SH]});
  assign sres    = neg2_r ? -smag : smag;
  assign res_nxt = WR'(sres);
  assign res     = res_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p00_r  <= p00_nxt;
      p01_r  <= p01_nxt;
      p10_r  <= p10_nxt;
      p11_r  <= p11_nxt;
      neg1_r <= neg;
      lo_r   <= lo_nxt;
      hi_r   <= hi_nxt;
      neg2_r <= neg1_r;
      res_r  <= res_nxt;
    end
  end

endmodule

// ===== hdl/esc_temp.sv =====
// Temperature compensation pipeline producing the output temperature and Q24 temperature.
module esc_temp (
  input  logic               clk,
  input  logic               en,
  input  esc_pkg::cal_t      cal,
  input  logic [19:0]        raw_t,
  output logic signed [14:0] tc,
  output logic signed [31:0] tq
);

  logic signed [15:0] t2;
  logic signed [7:0]  t3;
  logic signed [20:0] d_r, d_nxt;
  logic signed [36:0] dt2_r, dt2_nxt;
  logic signed [41:0] dd_full;
  logic [40:0]        dd_r;
  logic signed [52:0] a_r, a_nxt;
  logic signed [49:0] b_r, b_nxt;
  logic signed [53:0] n_r, n_nxt;
  logic [53:0]        an_r, an_nxt;
  logic               neg5_r, neg6_r, neg7_r;
  logic [56:0]        tsum;
  logic [54:0]        ysum;
  logic [38:0]        y;
  logic [18:0]        tcm_r;
  logic [32:0]        y6_r, y7_r;
  logic               sat_nxt, sat6_r, sat7_r;
  logic signed [19:0] tcs;
  logic signed [14:0] tc7_r, tc7_nxt, tc8_r;
  logic [65:0]        qprod;
  logic [30:0]        qest_r;
  logic [33:0]        rem;
  logic [31:0]        qfix;
  logic signed [31:0] tq_r, tq_nxt;

  assign t2 = cal.t2;
  assign t3 = cal.t3;

  assign d_nxt   = $signed({1'b0, raw_t}) - $signed({1'b0, cal.t1, 4'b0000});
  assign dt2_nxt = d_r * t2;
  assign dd_full = d_r * d_r;
  assign a_nxt   = $signed({dt2_r, 16'h0000});
  assign b_nxt   = $signed({1'b0, dd_r}) * t3;
  assign n_nxt   = 54'(a_r) + 54'(b_r);
  assign an_nxt  = n_r[53] ? 54'(-n_r) : 54'(n_r);

  assign tsum    = 57'({an_r, 2'b00}) + 57'(an_r) + 57'd137438953472;
  assign ysum    = 55'(an_r) + 55'd163840;
  assign y       = ysum[54:16];
  assign sat_nxt = neg5_r ? (y >= esc_pkg::Y_SAT_NEG) : (y >= esc_pkg::Y_SAT_POS);

  assign tcs     = neg6_r ? -$signed({1'b0, tcm_r}) : $signed({1'b0, tcm_r});
  assign tc7_nxt = (tcs < esc_pkg::TC_MIN) ? esc_pkg::TC_MIN :
                   (tcs > esc_pkg::TC_MAX) ? esc_pkg::TC_MAX : tcs[14:0];
  assign qprod   = 66'(y6_r) * 66'(esc_pkg::RECIP5);

  assign rem     = 34'(y7_r) - 34'({qest_r, 2'b00}) - 34'(qest_r);
  assign qfix    = (rem >= 34'd5) ? 32'(qest_r) + 32'd1 : 32'(qest_r);
  assign tq_nxt  = sat7_r ? (neg7_r ? esc_pkg::TQ_MIN : esc_pkg::TQ_MAX) :
                   (neg7_r ? -$signed(qfix) : $signed(qfix));

  assign tc = tc8_r;
  assign tq = tq_r;

  always_ff @(posedge clk) begin
    if (en) begin
      d_r    <= d_nxt;
      dt2_r  <= dt2_nxt;
      dd_r   <= dd_full[40:0];
      a_r    <= a_nxt;
      b_r    <= b_nxt;
      n_r    <= n_nxt;
      an_r   <= an_nxt;
      neg5_r <= n_r[53];
      tcm_r  <= tsum[56:38];
      y6_r   <= y[32:0];
      sat6_r <= sat_nxt;
      neg6_r <= neg5_r;
      tc7_r  <= tc7_nxt;
      qest_r <= qprod[65:35];
      y7_r   <= y6_r;
      sat7_r <= sat6_r;
      neg7_r <= neg6_r;
      tq_r   <= tq_nxt;
      tc8_r  <= tc7_r;
    end
  end

endmodule

// ===== hdl/esc_hum.sv =====
// Humidity compensation pipeline driven by the saturated Q24 temperature.
module esc_hum (
  input  logic               clk,
  input  logic               en,
  input  esc_pkg::cal_t      cal,
  input  logic signed [31:0] tq,
  input  logic [15:0]        raw_h,
  output logic [16:0]        hm
);

  localparam logic signed [43:0] P_ONE = 44'sh100_0000_0000;

  logic signed [7:0]  h3, h4, h5, h7;
  logic [7:0]         h6, h5mag;
  logic [31:0]        tqabs;
  logic signed [39:0] h4t, h7t, h3t;
  logic [61:0]        tsq1_r;
  logic signed [41:0] lin4_1_r, lin4_2_r, lin4_3_r;
  logic signed [39:0] h3t1_r;
  logic signed [16:0] hd1_r;
  logic signed [41:0] s_nxt;
  logic signed [41:0] s_dly_r [0:12];
  logic [69:0]        prod5_r;
  logic signed [42:0] v1_2_r, v1_3_r, v1_4_r, v1_5_r, v1_nxt;
  logic [70:0]        rsum;
  logic signed [42:0] r5_r, r5_nxt;
  logic signed [43:0] p4_r, p4_nxt;
  logic signed [56:0] g5_r, g5_nxt;
  logic [56:0]        gabs;
  logic [42:0]        vabs;
  logic [55:0]        gmag6_r;
  logic [42:0]        vmag6_r;
  logic               neg6_r;
  logic signed [45:0] v2;
  logic [45:0]        v2abs;
  logic [44:0]        v2mag_r;
  logic signed [45:0] v2_dly_r [0:7];
  logic signed [57:0] qq;
  logic [41:0]        smag_r;
  logic [56:0]        qmag_r;
  logic               neg14_r;
  logic signed [53:0] sq;
  logic signed [54:0] h18_r, h18_nxt;
  logic [54:0]        habs;
  logic [64:0]        hprod_r;
  logic               hneg_r;
  logic [65:0]        hsum;
  logic [33:0]        m;
  logic [16:0]        hm_r, hm_nxt;

  assign h3 = cal.hlin[7:0];
  assign h4 = cal.hlin[15:8];
  assign h5 = cal.hlin[23:16];
  assign h6 = cal.hsq[7:0];
  assign h7 = cal.hsq[15:8];
  assign h5mag = h5[7] ? 8'(-h5) : 8'(h5);

  assign tqabs = tq[31] ? 32'(-tq) : 32'(tq);
  assign h4t   = h4 * tq;
  assign h7t   = h7 * tq;
  assign h3t   = h3 * tq;
  assign s_nxt = $signed({3'b000, h6, 31'b0}) + 42'(h7t);

  assign v1_nxt = $signed({hd1_r, 25'b0}) - 43'(h3t1_r);
  assign rsum   = 71'(prod5_r) + 71'd134217728;
  assign r5_nxt = h5[7] ? -$signed({1'b0, rsum[69:28]}) : $signed({1'b0, rsum[69:28]});
  assign p4_nxt = P_ONE + 44'(lin4_3_r) + 44'(r5_r);
  assign g5_nxt = $signed({1'b0, cal.h2}) * p4_r;
  assign gabs   = g5_r[56] ? 57'(-g5_r) : 57'(g5_r);
  assign vabs   = v1_5_r[42] ? 43'(-v1_5_r) : 43'(v1_5_r);

  esc_mulrs #(.WA(43), .WB(56), .SH(51), .WR(46)) u_mul_v2 (
    .clk(clk), .en(en), .a(vmag6_r), .b(gmag6_r), .neg(neg6_r), .res(v2)
  );

  assign v2abs = v2[45] ? 46'(-v2) : 46'(v2);

  esc_mulrs #(.WA(45), .WB(45), .SH(32), .WR(58)) u_mul_sqr (
    .clk(clk), .en(en), .a(v2mag_r), .b(v2mag_r), .neg(1'b0), .res(qq)
  );

  esc_mulrs #(.WA(42), .WB(57), .SH(45), .WR(54)) u_mul_s (
    .clk(clk), .en(en), .a(smag_r), .b(qmag_r), .neg(neg14_r), .res(sq)
  );

  assign h18_nxt = 55'(v2_dly_r[7]) + 55'(sq);
  assign habs    = h18_r[54] ? 55'(-h18_r) : 55'(h18_r);
  assign hsum    = 66'(hprod_r) + 66'd2147483648;
  assign m       = hsum[65:32];
  assign hm_nxt  = hneg_r ? 17'd0 : ((m > 34'(esc_pkg::HM_MAX)) ? esc_pkg::HM_MAX : m[16:0]);
  assign hm      = hm_r;

  always_ff @(posedge clk) begin
    if (en) begin
      tsq1_r   <= tqabs[30:0] * tqabs[30:0];
      lin4_1_r <= $signed({h4t, 2'b00});
      h3t1_r   <= h3t;
      hd1_r    <= $signed({1'b0, raw_h}) - $signed({1'b0, cal.h1, 4'b0000});
      prod5_r  <= tsq1_r * h5mag;
      lin4_2_r <= lin4_1_r;
      v1_2_r   <= v1_nxt;
      r5_r     <= r5_nxt;
      lin4_3_r <= lin4_2_r;
      v1_3_r   <= v1_2_r;
      p4_r     <= p4_nxt;
      v1_4_r   <= v1_3_r;
      g5_r     <= g5_nxt;
      v1_5_r   <= v1_4_r;
      gmag6_r  <= gabs[55:0];
      vmag6_r  <= vabs;
      neg6_r   <= g5_r[56] ^ v1_5_r[42];
      v2mag_r  <= v2abs[44:0];
      smag_r   <= s_dly_r[12][41] ? 42'(-s_dly_r[12]) : 42'(s_dly_r[12]);
      qmag_r   <= qq[56:0];
      neg14_r  <= s_dly_r[12][41];
      h18_r    <= h18_nxt;
      hprod_r  <= 65'(habs[53:0]) * 65'd1000;
      hneg_r   <= h18_r[54];
      hm_r     <= hm_nxt;
      s_dly_r[0]  <= s_nxt;
      v2_dly_r[0] <= v2;
      for (int i = 1; i < 13; i++) begin
        s_dly_r[i] <= s_dly_r[i-1];
      end
      for (int i = 1; i < 8; i++) begin
        v2_dly_r[i] <= v2_dly_r[i-1];
      end
    end
  end

endmodule

// ===== hdl/esc_checker.sv =====
// Port-level checker for the compensation block and its bind to the top level.
module esc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("Output beat changed while stalled.");

  a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[14:0]) >= -15'sd4000) &&
                   ($signed(out_tdata[14:0]) <= 15'sd8500))
    else $error("Temperature outside the saturation range.");

  a_hum_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[31:15] <= 17'd100000)
    else $error("Humidity outside the clamp range.");

  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_tvalid || out_tready) |-> in_tready)
    else $error("Input not ready although the output stage is free.");

endmodule

bind env_sensor_compensation esc_checker u_esc_checker (.*);

// ===== sim/env_sensor_compensation_test.sv =====
// Self-checking testbench for the environment sensor compensation block.
`timescale 1ns / 1ps

module env_sensor_compensation_test;

  localparam logic [2:0] CFG_UNUSED = 3'd7;
  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_HOLD = 300;
  localparam int RAND_PHASES = 7;
  localparam int PHASE_ITEMS = 200;
  localparam longint TQ_LO = -40 * 64'sd16777216;
  localparam longint TQ_HI = 85 * 64'sd16777216;

  typedef struct packed {
    logic signed [14:0] temp_centi;
    logic [16:0]        hum_milli;
  } reading_t;

  typedef struct {
    int          cal_set;
    logic [19:0] raw_t;
    logic [15:0] raw_h;
    bit          typed;
    reading_t    want;
  } vector_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;   // raw_temperature [19:0], raw_humidity [35:20], zero [39:36]
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // temperature_centi [14:0], humidity_milli [31:15]
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [23:0] cfg_data;

  env_sensor_compensation u_dut (.*);

  esc_pkg::cal_t cal_copy;
  reading_t pending_readings[$];
  reading_t typed_readings[$];
  bit       typed_flags[$];
  int       mismatches;
  int       readings_seen;
  int       cycles;
  bit       no_idle;
  bit       hold_req;
  int       hold_left;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic longint round_mul(longint a, longint b, int s);
    logic [127:0] ua;
    logic [127:0] ub;
    logic [127:0] m;
    bit neg;
    neg = (a < 0) != (b < 0);
    ua = 128'(a < 0 ? -a : a);
    ub = 128'(b < 0 ? -b : b);
    m = (ua * ub + (128'd1 << (s - 1))) >> s;
    return neg ? -longint'({1'b0, m[62:0]}) : longint'({1'b0, m[62:0]});
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic reading_t compensate(esc_pkg::cal_t c, logic [19:0] raw_t,
                                          logic [15:0] raw_h);
    longint t1, t2, t3, h1, h2, h3, h4, h5, h6, h7;
    longint d, n, an, tq, p, g, v1, v2, s, q, h;
    reading_t r;
    t1 = longint'(c.t1);
    t2 = longint'($signed(c.t2));
    t3 = longint'($signed(c.t3));
    h1 = longint'(c.h1);
    h2 = longint'(c.h2);
    h3 = longint'($signed(c.hlin[7:0]));
    h4 = longint'($signed(c.hlin[15:8]));
    h5 = longint'($signed(c.hlin[23:16]));
    h6 = longint'(c.hsq[7:0]);
    h7 = longint'($signed(c.hsq[15:8]));
    d = longint'(raw_t) - 16 * t1;
    n = d * t2 * 65536 + d * d * t3;
    r.temp_centi = 15'(clip(round_mul(n, 5, 38), -4000, 8500));
    an = n < 0 ? -n : n;
    an = (an + 163840) / 327680;
    tq = clip(n < 0 ? -an : an, TQ_LO, TQ_HI);
    p = (64'sd1 <<< 40) + 4 * h4 * tq + round_mul(h5, tq * tq, 28);
    g = h2 * p;
    v1 = (longint'(raw_h) - 16 * h1) * (64'sd1 <<< 25) - h3 * tq;
    v2 = round_mul(v1, g, 51);
    s = h6 * (64'sd1 <<< 31) + h7 * tq;
    q = round_mul(v2, v2, 32);
    h = v2 + round_mul(s, q, 45);
    r.hum_milli = 17'(clip(round_mul(h, 1000, 32), 0, 100000));
    return r;
  endfunction

  // Handshakes are sampled in the monitor, before the edge's updates land.
  always @(posedge clk) begin
    reading_t got;
    reading_t want;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Run exceeded %0d cycles.", CYCLE_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
    if (rst_n && cfg_valid && cfg_ready) begin
      case (cfg_index)
        esc_pkg::CFG_TEMP_ONE:   cal_copy.t1   = cfg_data[15:0];
        esc_pkg::CFG_TEMP_TWO:   cal_copy.t2   = cfg_data[15:0];
        esc_pkg::CFG_TEMP_THREE: cal_copy.t3   = cfg_data[7:0];
        esc_pkg::CFG_HUM_ONE:    cal_copy.h1   = cfg_data[11:0];
        esc_pkg::CFG_HUM_TWO:    cal_copy.h2   = cfg_data[11:0];
        esc_pkg::CFG_HUM_LINEAR: cal_copy.hlin = cfg_data;
        esc_pkg::CFG_HUM_SQUARE: cal_copy.hsq  = cfg_data[15:0];
        default: ;
      endcase
    end
    if (rst_n && in_tvalid && in_tready) begin
      want = compensate(cal_copy, in_tdata[19:0], in_tdata[35:20]);
      if (typed_flags.size() > 0) begin
        if (typed_flags.pop_front()) want = typed_readings.pop_front();
      end
      pending_readings.push_back(want);
    end
    if (rst_n && out_tvalid && out_tready) begin
      got.temp_centi = out_tdata[14:0];
      got.hum_milli  = out_tdata[31:15];
      readings_seen++;
      if (pending_readings.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected beat %h with nothing pending.", out_tdata);
      end else begin
        want = pending_readings.pop_front();
        if (got.temp_centi !== want.temp_centi || got.hum_milli !== want.hum_milli) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Beat %0d: temperature %0d/%0d, humidity %0d/%0d (expected/actual).",
                     readings_seen, want.temp_centi, $signed(got.temp_centi),
                     want.hum_milli, got.hum_milli);
        end
      end
    end
  end

  initial begin
    out_tready = 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (no_idle) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= 24);
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [23:0] value);
    bit hs;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do begin
      @(negedge clk);
      hs = cfg_ready;
      @(posedge clk);
    end while (!hs);
  endtask

  task automatic settle();
    repeat (esc_pkg::PIPE_LAT + 4) @(posedge clk);
    while (pending_readings.size() != 0) @(posedge clk);
  endtask

  task automatic load_cal(esc_pkg::cal_t c);
    settle();
    write_reg(esc_pkg::CFG_TEMP_ONE, 24'(c.t1));
    write_reg(esc_pkg::CFG_TEMP_TWO, 24'(c.t2));
    write_reg(esc_pkg::CFG_TEMP_THREE, 24'(c.t3));
    write_reg(esc_pkg::CFG_HUM_ONE, 24'(c.h1));
    write_reg(esc_pkg::CFG_HUM_TWO, 24'(c.h2));
    write_reg(esc_pkg::CFG_HUM_LINEAR, c.hlin);
    write_reg(esc_pkg::CFG_HUM_SQUARE, 24'(c.hsq));
    write_reg(CFG_UNUSED, 24'($urandom));
    cfg_valid <= 1'b0;
  endtask

  task automatic send(logic [19:0] raw_t, logic [15:0] raw_h);
    bit hs;
    while (!no_idle && $urandom_range(0, 99) < 24) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {4'b0, raw_h, raw_t};
    do begin
      @(negedge clk);
      hs = in_tready;
      @(posedge clk);
    end while (!hs);
  endtask

  function automatic esc_pkg::cal_t plausible_cal();
    esc_pkg::cal_t c;
    c.t1 = 16'($urandom_range(24000, 28000));
    c.t2 = 16'($urandom_range(24000, 28000));
    c.t3 = 8'($urandom_range(1, 5));
    c.h1 = 12'($urandom_range(600, 900));
    c.h2 = 12'($urandom_range(900, 1100));
    c.hlin = {8'($urandom_range(0, 30)), 8'($urandom_range(30, 50)), 8'($urandom_range(0, 3))};
    c.hsq = {8'($urandom_range(156, 255)), 8'($urandom_range(80, 160))};
    return c;
  endfunction

  function automatic logic [19:0] near_t(esc_pkg::cal_t c);
    int v;
    v = 16 * int'(c.t1) + $urandom_range(0, 200000) - 50000;
    return 20'(v < 0 ? 0 : (v > 20'hFFFFF ? 20'hFFFFF : v));
  endfunction

  function automatic logic [15:0] near_h(esc_pkg::cal_t c);
    int v;
    v = 16 * int'(c.h1) + $urandom_range(0, 40000) - 8000;
    return 16'(v < 0 ? 0 : (v > 16'hFFFF ? 16'hFFFF : v));
  endfunction

  esc_pkg::cal_t cal_sets[4];
  vector_t       vectors[$];

  initial begin
    esc_pkg::cal_t c;
    int last_set;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    cal_copy = '0;
    mismatches = 0;
    readings_seen = 0;
    cycles = 0;
    no_idle = 1'b0;
    hold_req = 1'b0;

    cal_sets[0] = '0;
    cal_sets[1] = '{t1: 16'd0, t2: 16'h7FFF, t3: 8'h7F, default: '0};
    cal_sets[2] = '{t1: 16'hFFFF, t2: 16'h7FFF, default: '0};
    cal_sets[3] = '{t1: 16'd26000, t2: 16'd26200, t3: 8'd3, h1: 12'd750, h2: 12'd1000,
                    hlin: 24'h142D00, hsq: 16'h9C78};
    vectors = '{
      '{0, 20'h00000, 16'h0000, 1, '{15'sd0, 17'd0}},
      '{0, 20'hFFFFF, 16'hFFFF, 1, '{15'sd0, 17'd0}},
      '{0, 20'h80000, 16'h8000, 1, '{15'sd0, 17'd0}},
      '{1, 20'hFFFFF, 16'h0000, 1, '{15'sd8500, 17'd0}},
      '{1, 20'h00000, 16'hFFFF, 1, '{15'sd0, 17'd0}},
      '{1, 20'hFFFFF, 16'hFFFF, 1, '{15'sd8500, 17'd0}},
      '{2, 20'h00000, 16'h0000, 1, '{-15'sd4000, 17'd0}},
      '{2, 20'h00000, 16'hFFFF, 1, '{-15'sd4000, 17'd0}},
      '{3, 20'd500000, 16'd30000, 0, '0},
      '{3, 20'd500000, 16'd60000, 0, '0},
      '{3, 20'd500000, 16'h0000, 0, '0},
      '{3, 20'd500000, 16'hFFFF, 0, '0},
      '{3, 20'd416000, 16'd12000, 0, '0},
      '{3, 20'h00000, 16'd30000, 0, '0},
      '{3, 20'hFFFFF, 16'd30000, 0, '0},
      '{3, 20'd480000, 16'd45000, 0, '0},
      '{3, 20'd530000, 16'd20000, 0, '0}
    };

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    last_set = -1;
    foreach (vectors[i]) begin
      if (vectors[i].cal_set != last_set) begin
        last_set = vectors[i].cal_set;
        if (last_set != 0) begin
          in_tvalid <= 1'b0;
          load_cal(cal_sets[last_set]);
        end
      end
      typed_flags.push_back(vectors[i].typed);
      if (vectors[i].typed) typed_readings.push_back(vectors[i].want);
      send(vectors[i].raw_t, vectors[i].raw_h);
    end

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      in_tvalid <= 1'b0;
      case (ph)
        1: c = '1;
        4: c = '{t1: 16'hFFFF, t2: 16'h8000, t3: 8'h80, h1: 12'hFFF, h2: 12'hFFF,
                 hlin: 24'h808080, hsq: 16'h80FF};
        2, 5: c = esc_pkg::cal_t'({$urandom, $urandom, $urandom, $urandom});
        default: c = plausible_cal();
      endcase
      load_cal(c);
      no_idle = (ph == 3);
      if (ph == 5) hold_req = 1'b1;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        typed_flags.push_back(1'b0);
        if ($urandom_range(0, 1))
          send(20'($urandom), 16'($urandom));
        else
          send(near_t(c), near_h(c));
      end
    end
    in_tvalid <= 1'b0;
    no_idle = 1'b0;
    settle();

    $display("Checked %0d readings over %0d calibration sets, with saturation and clamping cases.",
             readings_seen, RAND_PHASES + 4);
    if (mismatches == 0 && pending_readings.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches, %0d readings outstanding.", mismatches,
               pending_readings.size());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
